### sv/ffsa_pkg.sv
package ffsa_pkg;
    localparam int MaxSegments = 64;
    localparam int IdxW = $clog2(MaxSegments);
    localparam int CntW = $clog2(MaxSegments + 1);
    localparam logic [31:0] HeaderBytes = 32'd12;
    localparam logic [31:0] SplitSlack = 32'd16;
    localparam logic [31:0] ResetBase = 32'd1048576;
    localparam logic [31:0] ResetSize = 32'd1048576;

    localparam logic [1:0] StOk = 2'd0;
    localparam logic [1:0] StNoFit = 2'd1;
    localparam logic [1:0] StBadAddr = 2'd2;

    localparam logic KindAlloc = 1'b0;
    localparam logic KindFree = 1'b1;

    localparam logic CfgBase = 1'b0;
    localparam logic CfgSize = 1'b1;

    typedef enum logic [2:0] {
        T_OP_NONE,
        T_OP_READ,
        T_OP_ALLOC,
        T_OP_SHIFT_UP,
        T_OP_SPLIT,
        T_OP_FREE,
        T_OP_MERGE_RD,
        T_OP_MERGE_SH
    } t_op;

    typedef struct packed {
        t_op            op;
        logic [IdxW-1:0] idx;
        logic [31:0]    req;
        logic           rebuild;
    } t_cmd;

    typedef struct packed {
        logic           rd_free;
        logic [31:0]    rd_start;
        logic [31:0]    rd_size;
        logic [CntW-1:0] count;
        logic [31:0]    used;
    } t_stat;
endpackage

### sv/ffsa_datapath.sv
module ffsa_datapath import ffsa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_base,
    input  logic [31:0] i_size,
    input  t_cmd        i_cmd,
    output t_stat       o_stat
);
    logic [31:0] mem_start [MaxSegments];
    logic [31:0] mem_size  [MaxSegments];
    logic        mem_free  [MaxSegments];

    logic [31:0]     r_rd_start, r_rd_size;
    logic            r_rd_free;
    logic [31:0]     r_held_start, r_held_size;
    logic            r_held_free;
    logic [CntW-1:0] r_count;
    logic [31:0]     r_used;

    logic            we;
    logic [IdxW-1:0] wa;
    logic [31:0]     wd_start, wd_size;
    logic            wd_free;
    logic [IdxW-1:0] ra;

    // Writes: one port. Reads: one port, registered.
    always_comb begin
        we = 1'b0;
        wa = i_cmd.idx;
        wd_start = r_rd_start;
        wd_size = r_rd_size;
        wd_free = r_rd_free;
        ra = i_cmd.idx;
        unique case (i_cmd.op)
            T_OP_ALLOC: begin
                we = 1'b1;
                wd_free = 1'b0;
                wd_size = i_cmd.req;
            end
            T_OP_SHIFT_UP: begin
                // move entry idx to idx+1, read idx-1 next
                we = 1'b1;
                wa = i_cmd.idx + 1'b1;
                ra = i_cmd.idx - 1'b1;
            end
            T_OP_SPLIT: begin
                we = 1'b1;
                wa = i_cmd.idx + 1'b1;
                wd_start = r_held_start + HeaderBytes + i_cmd.req;
                wd_size = r_held_size - i_cmd.req - HeaderBytes;
                wd_free = 1'b1;
            end
            T_OP_FREE: begin
                we = 1'b1;
                wd_start = r_rd_start;
                wd_size = r_rd_size;
                wd_free = 1'b1;
            end
            T_OP_MERGE_RD: begin
                // combine held entry idx-1 with read entry; write to idx-1
                we = 1'b1;
                wa = i_cmd.idx - 1'b1;
                wd_start = r_held_start;
                wd_size = r_held_size + HeaderBytes + r_rd_size;
                wd_free = 1'b1;
                ra = i_cmd.idx + 1'b1;
            end
            T_OP_MERGE_SH: begin
                // copy read entry down to idx-1
                we = 1'b1;
                wa = i_cmd.idx - 1'b1;
                ra = i_cmd.idx + 1'b1;
            end
            default: ;
        endcase
        if (i_cmd.rebuild) begin
            we = 1'b1;
            wa = '0;
            wd_start = i_base;
            wd_size = (i_size >= HeaderBytes) ? i_size - HeaderBytes : 32'd0;
            wd_free = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_start[wa] <= wd_start;
            mem_size[wa] <= wd_size;
            mem_free[wa] <= wd_free;
        end
        r_rd_start <= mem_start[ra];
        r_rd_size <= mem_size[ra];
        r_rd_free <= mem_free[ra];
        if (i_cmd.op == T_OP_READ || i_cmd.op == T_OP_FREE) begin
            r_held_start <= r_rd_start;
            r_held_size <= r_rd_size;
            r_held_free <= r_rd_free;
        end else if (i_cmd.op == T_OP_MERGE_RD) begin
            r_held_size <= wd_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.rebuild) begin
            r_count <= CntW'(1);
            r_used <= 32'd0;
        end else begin
            case (i_cmd.op)
                T_OP_ALLOC: r_used <= r_used + i_cmd.req + HeaderBytes;
                T_OP_SPLIT: r_count <= r_count + 1'b1;
                T_OP_FREE:  r_used <= r_used - r_rd_size - HeaderBytes;
                T_OP_MERGE_RD: r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    assign o_stat.rd_free = r_rd_free & ~r_held_free | r_rd_free;
    assign o_stat.rd_start = r_rd_start;
    assign o_stat.rd_size = r_rd_size;
    assign o_stat.count = r_count;
    assign o_stat.used = r_used;
endmodule

### sv/ffsa_ctrl.sv
module ffsa_ctrl import ffsa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [31:0] i_req_size,
    input  logic [31:0] i_address,
    input  logic        i_rebuild,
    input  logic [31:0] i_heap_size,
    input  t_stat       i_stat,
    output t_cmd        o_cmd,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_result_address,
    output logic [31:0] o_used_bytes,
    output logic [31:0] o_free_bytes
);
    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_CHECK, S_SHIFT, S_SPLIT, S_MSTART, S_MCHK,
        S_MSH, S_REPORT, S_OUT
    } t_state;

    t_state          r_state;
    logic            r_kind;
    logic [31:0]     r_req, r_addr;
    logic [CntW-1:0] r_i;
    logic [IdxW-1:0] r_hit, r_sh;
    logic            r_split;
    logic [1:0]      r_status;
    logic [31:0]     r_res;
    logic            r_prev_free;
    logic            r_out_valid;
    logic [1:0]      r_out_status;
    logic [31:0]     r_out_res, r_out_used, r_out_free;

    logic [32:0] limit;
    logic        fit, match, last;

    assign limit = {1'b0, r_req} + 33'(HeaderBytes) + 33'(SplitSlack);
    assign fit = i_stat.rd_free && (i_stat.rd_size >= r_req);
    assign match = !i_stat.rd_free && (i_stat.rd_start + HeaderBytes == r_addr);
    assign last = (r_i + 1'b1 >= i_stat.count);

    always_comb begin
        o_cmd.op = T_OP_NONE;
        o_cmd.idx = r_i[IdxW-1:0];
        o_cmd.req = r_req;
        o_cmd.rebuild = i_rebuild;
        unique case (r_state)
            S_SCAN:  o_cmd.op = T_OP_READ;
            S_CHECK: begin
                if (r_kind == KindAlloc && fit) begin
                    if ({1'b0, i_stat.rd_size} > limit
                        && i_stat.count != CntW'(MaxSegments)) begin
                        o_cmd.op = T_OP_READ;
                    end else begin
                        o_cmd.op = T_OP_ALLOC;
                        o_cmd.req = i_stat.rd_size;
                    end
                end else if (r_kind == KindFree && match) begin
                    o_cmd.op = T_OP_FREE;
                end else if (!last) begin
                    o_cmd.op = T_OP_READ;
                    o_cmd.idx = r_i[IdxW-1:0] + 1'b1;
                end
            end
            S_SHIFT: begin
                o_cmd.idx = r_sh;
                o_cmd.op = (r_sh == r_hit) ? T_OP_SPLIT : T_OP_SHIFT_UP;
            end
            S_SPLIT: begin
                o_cmd.idx = r_hit;
                o_cmd.op = T_OP_ALLOC;
            end
            S_MSTART: o_cmd.op = T_OP_READ;
            S_MCHK: begin
                if (r_prev_free && i_stat.rd_free) o_cmd.op = T_OP_MERGE_RD;
                else o_cmd.op = T_OP_READ;
                if (!(r_prev_free && i_stat.rd_free)) o_cmd.idx = r_i[IdxW-1:0] + 1'b1;
            end
            S_MSH: begin
                o_cmd.idx = r_i[IdxW-1:0] + 1'b1;
                o_cmd.op = T_OP_MERGE_SH;
            end
            default: ;
        endcase
        if (o_cmd.op == T_OP_READ && r_state == S_CHECK && r_kind == KindAlloc && fit)
            o_cmd.idx = i_stat.count[IdxW-1:0] - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_REPORT) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_kind <= i_kind;
                    r_req <= i_req_size;
                    r_addr <= i_address;
                    r_i <= '0;
                    r_res <= 32'd0;
                    r_status <= StOk;
                    if (i_kind == KindFree && i_address == 32'd0) r_state <= S_REPORT;
                    else r_state <= S_SCAN;
                end
                S_SCAN: r_state <= S_CHECK;
                S_CHECK: begin
                    if (r_kind == KindAlloc && fit) begin
                        r_hit <= r_i[IdxW-1:0];
                        r_res <= i_stat.rd_start + HeaderBytes;
                        if ({1'b0, i_stat.rd_size} > limit
                            && i_stat.count != CntW'(MaxSegments)) begin
                            r_sh <= i_stat.count[IdxW-1:0] - 1'b1;
                            r_state <= S_SHIFT;
                        end else begin
                            r_state <= S_REPORT;
                        end
                    end else if (r_kind == KindFree && match) begin
                        r_i <= '0;
                        r_state <= S_MSTART;
                    end else if (last) begin
                        r_status <= (r_kind == KindAlloc) ? StNoFit : StBadAddr;
                        r_state <= S_REPORT;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_SHIFT: begin
                    if (r_sh == r_hit) r_state <= S_SPLIT;
                    else r_sh <= r_sh - 1'b1;
                end
                S_SPLIT: r_state <= S_REPORT;
                S_MSTART: begin
                    r_prev_free <= 1'b0;
                    r_state <= (i_stat.count <= CntW'(1)) ? S_REPORT : S_MCHK;
                end
                S_MCHK: begin
                    if (r_prev_free && i_stat.rd_free) begin
                        r_sh <= r_i[IdxW-1:0] + 1'b1;
                        if (r_i + 1'b1 >= i_stat.count) r_state <= S_REPORT;
                        else r_state <= S_MSH;
                    end else begin
                        r_prev_free <= i_stat.rd_free;
                        if (r_i + 1'b1 >= i_stat.count) r_state <= S_REPORT;
                        else r_i <= r_i + 1'b1;
                    end
                end
                S_MSH: begin
                    if (r_i + 1'b1 >= i_stat.count + 1'b1 - 1'b1) begin
                        r_i <= CntW'(0);
                        r_state <= S_MSTART;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_REPORT: if (!r_out_valid || i_out_ready) begin
                    r_out_valid <= 1'b1;
                    r_out_status <= r_status;
                    r_out_res <= r_res;
                    r_out_used <= i_stat.used;
                    r_out_free <= (i_heap_size >= i_stat.used) ?
                                  i_heap_size - i_stat.used : 32'd0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status = r_out_status;
    assign o_result_address = r_out_res;
    assign o_used_bytes = r_out_used;
    assign o_free_bytes = r_out_free;
endmodule

### sv/first_fit_segment_allocator.sv
// First-fit heap segment allocator.
// Input channel (i_in_valid/o_in_ready) carries one request beat: kind,
// req_size and address. Output channel (o_out_valid/i_out_ready) returns
// one result beat per request: status, granted address, used and free bytes.
// Configuration: i_cfg_we with i_cfg_index 0 (heap_base) or 1 (heap_size);
// a heap_size write, once registered, rebuilds the table to one free segment.
// The segment table has one write and one registered read port and is walked
// one entry per cycle. An allocate walks the entries until the first fit; when
// it splits, the entries above the hit are shifted up one per cycle, the split
// remainder is written just above the hit and the hit is allocated. A free
// scans for its address, then makes one pass over the table and one more pass
// per merge (two at most); a free of 0 skips the scan and goes to the report.
// The next beat is accepted the cycle after the result is registered.
// Reset restores heap_base and heap_size to 1 MiB and the table to one free
// segment. A result waits in the output register while the receiver
// stalls; the next request is taken and worked, and its result waits
// until the register frees.
module first_fit_segment_allocator import ffsa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [31:0] i_req_size,
    input  logic [31:0] i_address,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_result_address,
    output logic [31:0] o_used_bytes,
    output logic [31:0] o_free_bytes
);
    logic [31:0] r_base, r_size;
    logic        r_rebuild;
    t_cmd        cmd;
    t_stat       stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= ResetBase;
            r_size <= ResetSize;
            r_rebuild <= 1'b1;
        end else begin
            r_rebuild <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CfgBase: r_base <= i_cfg_data;
                    CfgSize: begin
                        r_size <= i_cfg_data;
                        r_rebuild <= 1'b1;
                    end
                endcase
            end
        end
    end

    ffsa_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_kind, .i_req_size,
        .i_address, .i_rebuild(r_rebuild), .i_heap_size(r_size),
        .i_stat(stat), .o_cmd(cmd), .o_out_valid, .i_out_ready, .o_status,
        .o_result_address, .o_used_bytes, .o_free_bytes
    );

    ffsa_datapath u_dp (
        .i_clk, .i_rst_n, .i_base(r_base), .i_size(r_size),
        .i_cmd(cmd), .o_stat(stat)
    );
endmodule
